FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the scorer top level.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check an expression on every rising clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// check that an antecedent implies a consequent in the same cycle
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`endif

FILE: rtl/core/dbms_pkg.sv
// ----------------------------------------------------------------------------
// dbms_pkg
// Shared constants, types and lookup functions of the degenerate base scorer.
// ----------------------------------------------------------------------------
package dbms_pkg;

   localparam int COUNT_WIDTH_DEF = 16;
   localparam int CSR_INDEX_W     = 3;
   localparam int CSR_DATA_W      = 10;
   localparam int WEIGHT_W        = 8;
   localparam int PERMILLE_W      = 10;
   localparam int LEN_W           = 16;
   localparam int PROD_W          = LEN_W + PERMILLE_W;
   localparam int CODE_W          = 4;
   localparam int SCORE_W         = 32;
   localparam int OUT_COUNT_W     = 16;

   localparam logic [PERMILLE_W-1:0] PERMILLE_MAX = 10'd1000;
   localparam int                    THOUSAND     = 1000;

   localparam logic [WEIGHT_W-1:0]   STRONG_WEIGHT_RST   = 8'd8;
   localparam logic [WEIGHT_W-1:0]   MEDIUM_WEIGHT_RST   = 8'd4;
   localparam logic [WEIGHT_W-1:0]   WEAK_WEIGHT_RST     = 8'd2;
   localparam logic [WEIGHT_W-1:0]   RUN_WEIGHT_MULT_RST = 8'd1;
   localparam logic [PERMILLE_W-1:0] BAIL_PERMILLE_RST   = 10'd1000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_STRONG_WEIGHT   = 3'd0,
      CSR_MEDIUM_WEIGHT   = 3'd1,
      CSR_WEAK_WEIGHT     = 3'd2,
      CSR_RUN_WEIGHT_MULT = 3'd3,
      CSR_BAIL_PERMILLE   = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      GRADE_NONE      = 3'd0,
      GRADE_STRONG    = 3'd1,
      GRADE_MEDIUM    = 3'd2,
      GRADE_WEAK      = 3'd3,
      GRADE_VERY_WEAK = 3'd4
   } grade_type;

   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } item_ctrl_type;

   typedef struct packed {
      logic valid;
      logic bailed;
   } result_ctrl_type;

   // bit 0 A, bit 1 C, bit 2 G, bit 3 T
   localparam logic [3:0] BASE_SET [16] = '{
      4'b0000, 4'b0010, 4'b0100, 4'b1000,
      4'b0001, 4'b0101, 4'b1010, 4'b1100,
      4'b0011, 4'b0110, 4'b1001, 4'b1110,
      4'b1101, 4'b1011, 4'b0111, 4'b1111
   };

   localparam logic [CODE_W-1:0] CODE_NONE   = 4'd0;
   localparam logic [CODE_W-1:0] CODE_A      = 4'd4;
   localparam logic [CODE_W-1:0] CODE_W_LAST = 4'd10;
   localparam logic [CODE_W-1:0] CODE_N      = 4'd15;

   function automatic logic [CODE_W-1:0] letter_code(input logic [7:0] ch);
      logic [CODE_W-1:0] code;
      case (ch)
         "C":     code = 4'd1;
         "G":     code = 4'd2;
         "T":     code = 4'd3;
         "A":     code = 4'd4;
         "R":     code = 4'd5;
         "Y":     code = 4'd6;
         "K":     code = 4'd7;
         "M":     code = 4'd8;
         "S":     code = 4'd9;
         "W":     code = 4'd10;
         "B":     code = 4'd11;
         "D":     code = 4'd12;
         "H":     code = 4'd13;
         "V":     code = 4'd14;
         "N":     code = 4'd15;
         default: code = CODE_NONE;
      endcase
      return code;
   endfunction

   function automatic grade_type grade_pair(input logic [CODE_W-1:0] ca,
                                            input logic [CODE_W-1:0] cb);
      grade_type g;
      if (ca == CODE_N) begin
         g = GRADE_VERY_WEAK;
      end else if (ca == CODE_NONE || (BASE_SET[ca] & BASE_SET[cb]) == 4'b0000) begin
         g = GRADE_NONE;
      end else if (ca <= CODE_A) begin
         g = GRADE_STRONG;
      end else if (ca <= CODE_W_LAST) begin
         g = GRADE_MEDIUM;
      end else begin
         g = GRADE_WEAK;
      end
      return g;
   endfunction

endpackage

FILE: rtl/core/dbms_channels.sv
// ----------------------------------------------------------------------------
// dbms_channels
// Valid/ready channel interfaces for base pairs in and scores out.
// ----------------------------------------------------------------------------
interface dbms_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  base_a;
   logic [7:0]  base_b;
   logic [15:0] compare_length;
   logic        last_pair;

   modport source (output valid, base_a, base_b, compare_length, last_pair,
                   input ready);
   modport sink (input valid, base_a, base_b, compare_length, last_pair,
                 output ready);
endinterface

interface dbms_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] match_score;
   logic [15:0] strong_count;
   logic [15:0] medium_count;
   logic [15:0] weak_count;
   logic [15:0] very_weak_count;
   logic [15:0] mismatch_count;
   logic        bailed;

   modport source (output valid, match_score, strong_count, medium_count,
                   weak_count, very_weak_count, mismatch_count, bailed,
                   input ready);
   modport sink (input valid, match_score, strong_count, medium_count,
                 weak_count, very_weak_count, mismatch_count, bailed,
                 output ready);
endinterface

FILE: rtl/core/dbms_grader.sv
// ----------------------------------------------------------------------------
// dbms_grader
// Input register, pair grading and scaled mismatch limit product.
// ----------------------------------------------------------------------------
module dbms_grader (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    en,
   input  logic                                    in_valid,
   input  logic [7:0]                              base_a,
   input  logic [7:0]                              base_b,
   input  logic [dbms_pkg::LEN_W-1:0]              compare_length,
   input  logic                                    last_pair,
   input  logic [dbms_pkg::PERMILLE_W-1:0]         bail_permille,
   output dbms_pkg::item_ctrl_type                 out_ctrl,
   output dbms_pkg::grade_type                     out_grade,
   output logic [dbms_pkg::PROD_W-1:0]             out_prod
);

   logic                               open_ff;
   dbms_pkg::item_ctrl_type            s1_ctrl_ff;
   logic [7:0]                         s1_a_ff;
   logic [7:0]                         s1_b_ff;
   logic [dbms_pkg::LEN_W-1:0]         s1_len_ff;
   dbms_pkg::item_ctrl_type            s2_ctrl_ff;
   dbms_pkg::grade_type                s2_grade_ff;
   dbms_pkg::grade_type                s2_grade_in;
   logic [dbms_pkg::PROD_W-1:0]        s2_prod_ff;
   logic [dbms_pkg::PROD_W-1:0]        s2_prod_in;
   logic [dbms_pkg::PERMILLE_W-1:0]    pm_clamped;

   always_comb begin
      pm_clamped = (bail_permille > dbms_pkg::PERMILLE_MAX) ? dbms_pkg::PERMILLE_MAX
                                                            : bail_permille;
      s2_prod_in = dbms_pkg::PROD_W'(s1_len_ff) * dbms_pkg::PROD_W'(pm_clamped);
      s2_grade_in = dbms_pkg::grade_pair(dbms_pkg::letter_code(s1_a_ff),
                                         dbms_pkg::letter_code(s1_b_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff    <= 1'b0;
         s1_ctrl_ff <= '0;
         s2_ctrl_ff <= '0;
      end else if (en) begin
         s1_ctrl_ff.valid <= in_valid;
         s1_ctrl_ff.first <= !open_ff;
         s1_ctrl_ff.last  <= last_pair;
         if (in_valid) begin
            open_ff <= !last_pair;
         end
         s2_ctrl_ff <= s1_ctrl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (in_valid) begin
            s1_a_ff   <= base_a;
            s1_b_ff   <= base_b;
            s1_len_ff <= compare_length;
         end
         s2_grade_ff <= s2_grade_in;
         s2_prod_ff  <= s2_prod_in;
      end
   end

   assign out_ctrl  = s2_ctrl_ff;
   assign out_grade = s2_grade_ff;
   assign out_prod  = s2_prod_ff;

endmodule

FILE: rtl/core/dbms_tally.sv
// ----------------------------------------------------------------------------
// dbms_tally
// Grade tallies, run weight, mismatch limit check and end-of-pair capture.
// ----------------------------------------------------------------------------
module dbms_tally #(
   parameter int COUNT_WIDTH = dbms_pkg::COUNT_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  dbms_pkg::item_ctrl_type             in_ctrl,
   input  dbms_pkg::grade_type                 in_grade,
   input  logic [dbms_pkg::PROD_W-1:0]         in_prod,
   input  logic [dbms_pkg::WEIGHT_W-1:0]       run_weight_mult,
   output dbms_pkg::result_ctrl_type           res_ctrl,
   output logic [COUNT_WIDTH-1:0]              res_strong,
   output logic [COUNT_WIDTH-1:0]              res_medium,
   output logic [COUNT_WIDTH-1:0]              res_weak,
   output logic [COUNT_WIDTH-1:0]              res_very_weak,
   output logic [COUNT_WIDTH-1:0]              res_mismatch,
   output logic [dbms_pkg::SCORE_W-1:0]        res_run_weight
);

   localparam int CW   = COUNT_WIDTH;
   localparam int TW   = CW + 10;
   localparam int CMPW = (TW > dbms_pkg::PROD_W) ? TW : dbms_pkg::PROD_W;
   localparam int MW   = CW + dbms_pkg::WEIGHT_W;
   localparam int FW   = ((MW + 1 > dbms_pkg::SCORE_W) ? MW + 1 : dbms_pkg::SCORE_W) + 1;

   function automatic logic [CW-1:0] bump(input logic [CW-1:0] v);
      return (v == {CW{1'b1}}) ? v : v + 1'b1;
   endfunction

   logic [CW-1:0]                     strong_ff, strong_in, old_strong;
   logic [CW-1:0]                     medium_ff, medium_in, old_medium;
   logic [CW-1:0]                     weak_ff, weak_in, old_weak;
   logic [CW-1:0]                     vweak_ff, vweak_in, old_vweak;
   logic [CW-1:0]                     mism_ff, mism_in, old_mism;
   logic [CW-1:0]                     run_ff, run_in, old_run;
   logic [TW-1:0]                     thr_ff, thr_in, old_thr;
   logic [dbms_pkg::SCORE_W-1:0]      acc_ff, acc_in, old_acc;
   logic [dbms_pkg::PROD_W-1:0]       limit_ff, limit;
   logic                              stop_ff, stop_in, old_stop;
   logic [CW-1:0]                     fold_len;
   logic [MW-1:0]                     fold_prod;
   logic [FW-1:0]                     fold_sum;

   dbms_pkg::result_ctrl_type         res_ctrl_ff;
   logic [CW-1:0]                     res_strong_ff, res_medium_ff, res_weak_ff;
   logic [CW-1:0]                     res_vweak_ff, res_mism_ff;
   logic [dbms_pkg::SCORE_W-1:0]      res_acc_ff;

   always_comb begin
      old_strong = in_ctrl.first ? '0 : strong_ff;
      old_medium = in_ctrl.first ? '0 : medium_ff;
      old_weak   = in_ctrl.first ? '0 : weak_ff;
      old_vweak  = in_ctrl.first ? '0 : vweak_ff;
      old_mism   = in_ctrl.first ? '0 : mism_ff;
      old_run    = in_ctrl.first ? '0 : run_ff;
      old_acc    = in_ctrl.first ? '0 : acc_ff;
      old_stop   = in_ctrl.first ? 1'b0 : stop_ff;
      old_thr    = in_ctrl.first ? TW'(dbms_pkg::THOUSAND) : thr_ff;
      limit      = in_ctrl.first ? in_prod : limit_ff;

      strong_in = old_strong;
      medium_in = old_medium;
      weak_in   = old_weak;
      vweak_in  = old_vweak;
      mism_in   = old_mism;
      run_in    = old_run;
      thr_in    = old_thr;
      stop_in   = old_stop;
      fold_len  = '0;

      if (!old_stop) begin
         case (in_grade)
            dbms_pkg::GRADE_STRONG:    strong_in = bump(old_strong);
            dbms_pkg::GRADE_MEDIUM:    medium_in = bump(old_medium);
            dbms_pkg::GRADE_WEAK:      weak_in   = bump(old_weak);
            dbms_pkg::GRADE_VERY_WEAK: vweak_in  = bump(old_vweak);
            default:                   ;
         endcase
         if (in_grade == dbms_pkg::GRADE_NONE) begin
            fold_len = old_run;
            run_in   = '0;
            mism_in  = bump(old_mism);
            thr_in   = (old_mism == {CW{1'b1}}) ? old_thr
                                                : old_thr + TW'(dbms_pkg::THOUSAND);
            stop_in  = CMPW'(thr_in) > CMPW'(limit);
         end else begin
            run_in   = bump(old_run);
            fold_len = in_ctrl.last ? run_in : '0;
         end
      end

      fold_prod = MW'(fold_len) * MW'(run_weight_mult);
      fold_sum  = FW'(old_acc) + FW'({fold_prod, 1'b0});
      acc_in    = (fold_sum > FW'({dbms_pkg::SCORE_W{1'b1}})) ? '1
                                                              : fold_sum[dbms_pkg::SCORE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stop_ff     <= 1'b0;
         res_ctrl_ff <= '0;
      end else if (en) begin
         if (in_ctrl.valid) begin
            stop_ff <= stop_in;
         end
         res_ctrl_ff.valid  <= in_ctrl.valid && in_ctrl.last;
         res_ctrl_ff.bailed <= stop_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en && in_ctrl.valid) begin
         strong_ff <= strong_in;
         medium_ff <= medium_in;
         weak_ff   <= weak_in;
         vweak_ff  <= vweak_in;
         mism_ff   <= mism_in;
         run_ff    <= run_in;
         thr_ff    <= thr_in;
         acc_ff    <= acc_in;
         limit_ff  <= limit;
         if (in_ctrl.last) begin
            res_strong_ff <= strong_in;
            res_medium_ff <= medium_in;
            res_weak_ff   <= weak_in;
            res_vweak_ff  <= vweak_in;
            res_mism_ff   <= mism_in;
            res_acc_ff    <= acc_in;
         end
      end
   end

   assign res_ctrl       = res_ctrl_ff;
   assign res_strong     = res_strong_ff;
   assign res_medium     = res_medium_ff;
   assign res_weak       = res_weak_ff;
   assign res_very_weak  = res_vweak_ff;
   assign res_mismatch   = res_mism_ff;
   assign res_run_weight = res_acc_ff;

endmodule

FILE: rtl/core/dbms_score.sv
// ----------------------------------------------------------------------------
// dbms_score
// Weighted score products, final sum with rejection rule, output register.
// ----------------------------------------------------------------------------
module dbms_score #(
   parameter int COUNT_WIDTH = dbms_pkg::COUNT_WIDTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   en,
   input  dbms_pkg::result_ctrl_type              res_ctrl,
   input  logic [COUNT_WIDTH-1:0]                 res_strong,
   input  logic [COUNT_WIDTH-1:0]                 res_medium,
   input  logic [COUNT_WIDTH-1:0]                 res_weak,
   input  logic [COUNT_WIDTH-1:0]                 res_very_weak,
   input  logic [COUNT_WIDTH-1:0]                 res_mismatch,
   input  logic [dbms_pkg::SCORE_W-1:0]           res_run_weight,
   input  logic [dbms_pkg::WEIGHT_W-1:0]          strong_weight,
   input  logic [dbms_pkg::WEIGHT_W-1:0]          medium_weight,
   input  logic [dbms_pkg::WEIGHT_W-1:0]          weak_weight,
   output logic                                   out_valid,
   output logic [dbms_pkg::SCORE_W-1:0]           match_score,
   output logic [dbms_pkg::OUT_COUNT_W-1:0]       strong_count,
   output logic [dbms_pkg::OUT_COUNT_W-1:0]       medium_count,
   output logic [dbms_pkg::OUT_COUNT_W-1:0]       weak_count,
   output logic [dbms_pkg::OUT_COUNT_W-1:0]       very_weak_count,
   output logic [dbms_pkg::OUT_COUNT_W-1:0]       mismatch_count,
   output logic                                   bailed
);

   localparam int CW  = COUNT_WIDTH;
   localparam int PW  = CW + dbms_pkg::WEIGHT_W;
   localparam int SW  = ((PW > dbms_pkg::SCORE_W) ? PW : dbms_pkg::SCORE_W) + 3;
   localparam int OCW = dbms_pkg::OUT_COUNT_W;

   dbms_pkg::result_ctrl_type      b_ctrl_ff;
   logic [PW-1:0]                  b_ps_ff, b_pm_ff, b_pw_ff;
   logic [CW-1:0]                  b_vweak_ff;
   logic [dbms_pkg::SCORE_W-1:0]   b_acc_ff;
   logic                           b_keep_ff, b_keep_in;
   logic [OCW-1:0]                 b_strong_ff, b_medium_ff, b_weak_ff, b_vw_out_ff, b_mism_ff;
   logic [SW-1:0]                  sum;
   logic [dbms_pkg::SCORE_W-1:0]   score_in;

   logic                           valid_ff;
   logic [dbms_pkg::SCORE_W-1:0]   score_ff;
   logic [OCW-1:0]                 strong_ff, medium_ff, weak_ff, vweak_ff, mism_ff;
   logic                           bailed_ff;

   always_comb begin
      b_keep_in = (res_strong != '0) &&
                  ((CW + 2)'(res_very_weak) <= (CW + 2)'(res_strong) + (CW + 2)'(res_medium)
                                               + (CW + 2)'(res_weak));
      sum = SW'(b_acc_ff) + SW'(b_ps_ff) + SW'(b_pm_ff) + SW'(b_pw_ff) + SW'(b_vweak_ff);
      if (!b_keep_ff) begin
         score_in = '0;
      end else if (sum > SW'({dbms_pkg::SCORE_W{1'b1}})) begin
         score_in = '1;
      end else begin
         score_in = sum[dbms_pkg::SCORE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_ctrl_ff <= '0;
         valid_ff  <= 1'b0;
      end else if (en) begin
         b_ctrl_ff <= res_ctrl;
         valid_ff  <= b_ctrl_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (res_ctrl.valid) begin
            b_ps_ff     <= PW'(res_strong) * PW'(strong_weight);
            b_pm_ff     <= PW'(res_medium) * PW'(medium_weight);
            b_pw_ff     <= PW'(res_weak) * PW'(weak_weight);
            b_vweak_ff  <= res_very_weak;
            b_acc_ff    <= res_run_weight;
            b_keep_ff   <= b_keep_in;
            b_strong_ff <= OCW'(res_strong);
            b_medium_ff <= OCW'(res_medium);
            b_weak_ff   <= OCW'(res_weak);
            b_vw_out_ff <= OCW'(res_very_weak);
            b_mism_ff   <= OCW'(res_mismatch);
         end
         if (b_ctrl_ff.valid) begin
            score_ff  <= score_in;
            strong_ff <= b_strong_ff;
            medium_ff <= b_medium_ff;
            weak_ff   <= b_weak_ff;
            vweak_ff  <= b_vw_out_ff;
            mism_ff   <= b_mism_ff;
            bailed_ff <= b_ctrl_ff.bailed;
         end
      end
   end

   assign out_valid       = valid_ff;
   assign match_score     = score_ff;
   assign strong_count    = strong_ff;
   assign medium_count    = medium_ff;
   assign weak_count      = weak_ff;
   assign very_weak_count = vweak_ff;
   assign mismatch_count  = mism_ff;
   assign bailed          = bailed_ff;

endmodule

FILE: rtl/core/degenerate_base_match_scorer.sv
// ----------------------------------------------------------------------------
// degenerate_base_match_scorer
// A result becomes valid only after a last pair is accepted.
// Throughput: one item per cycle; the pipeline stalls only on a held result.
// Reset: clears all stage valids and the open-comparison flag; the five
// weight and limit registers return to their defaults.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module degenerate_base_match_scorer #(
   parameter int COUNT_WIDTH = dbms_pkg::COUNT_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   dbms_req_if.sink                            req_ch,
   dbms_rsp_if.source                          rsp_ch,
   input  logic                                csr_write_en,
   input  logic [dbms_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [dbms_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   logic [dbms_pkg::WEIGHT_W-1:0]     strong_weight_ff;
   logic [dbms_pkg::WEIGHT_W-1:0]     medium_weight_ff;
   logic [dbms_pkg::WEIGHT_W-1:0]     weak_weight_ff;
   logic [dbms_pkg::WEIGHT_W-1:0]     run_mult_ff;
   logic [dbms_pkg::PERMILLE_W-1:0]   bail_permille_ff;

   logic                              pipe_en;
   dbms_pkg::item_ctrl_type           g_ctrl;
   dbms_pkg::grade_type               g_grade;
   logic [dbms_pkg::PROD_W-1:0]       g_prod;
   dbms_pkg::result_ctrl_type         t_ctrl;
   logic [COUNT_WIDTH-1:0]            t_strong, t_medium, t_weak, t_vweak, t_mism;
   logic [dbms_pkg::SCORE_W-1:0]      t_run_weight;

   always_ff @(posedge clock) begin
      if (reset) begin
         strong_weight_ff <= dbms_pkg::STRONG_WEIGHT_RST;
         medium_weight_ff <= dbms_pkg::MEDIUM_WEIGHT_RST;
         weak_weight_ff   <= dbms_pkg::WEAK_WEIGHT_RST;
         run_mult_ff      <= dbms_pkg::RUN_WEIGHT_MULT_RST;
         bail_permille_ff <= dbms_pkg::BAIL_PERMILLE_RST;
      end else if (csr_write_en) begin
         case (dbms_pkg::csr_index_type'(csr_index))
            dbms_pkg::CSR_STRONG_WEIGHT:   strong_weight_ff <= csr_wdata[7:0];
            dbms_pkg::CSR_MEDIUM_WEIGHT:   medium_weight_ff <= csr_wdata[7:0];
            dbms_pkg::CSR_WEAK_WEIGHT:     weak_weight_ff   <= csr_wdata[7:0];
            dbms_pkg::CSR_RUN_WEIGHT_MULT: run_mult_ff      <= csr_wdata[7:0];
            dbms_pkg::CSR_BAIL_PERMILLE:   bail_permille_ff <= csr_wdata;
            default:                       ;
         endcase
      end
   end

   // advance every stage unless a result is held at the output
   assign pipe_en      = !rsp_ch.valid || rsp_ch.ready;
   assign req_ch.ready = pipe_en;

   dbms_grader u_grader (
      .clock          (clock),
      .reset          (reset),
      .en             (pipe_en),
      .in_valid       (req_ch.valid),
      .base_a         (req_ch.base_a),
      .base_b         (req_ch.base_b),
      .compare_length (req_ch.compare_length),
      .last_pair      (req_ch.last_pair),
      .bail_permille  (bail_permille_ff),
      .out_ctrl       (g_ctrl),
      .out_grade      (g_grade),
      .out_prod       (g_prod)
   );

   dbms_tally #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_tally (
      .clock           (clock),
      .reset           (reset),
      .en              (pipe_en),
      .in_ctrl         (g_ctrl),
      .in_grade        (g_grade),
      .in_prod         (g_prod),
      .run_weight_mult (run_mult_ff),
      .res_ctrl        (t_ctrl),
      .res_strong      (t_strong),
      .res_medium      (t_medium),
      .res_weak        (t_weak),
      .res_very_weak   (t_vweak),
      .res_mismatch    (t_mism),
      .res_run_weight  (t_run_weight)
   );

   dbms_score #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_score (
      .clock           (clock),
      .reset           (reset),
      .en              (pipe_en),
      .res_ctrl        (t_ctrl),
      .res_strong      (t_strong),
      .res_medium      (t_medium),
      .res_weak        (t_weak),
      .res_very_weak   (t_vweak),
      .res_mismatch    (t_mism),
      .res_run_weight  (t_run_weight),
      .strong_weight   (strong_weight_ff),
      .medium_weight   (medium_weight_ff),
      .weak_weight     (weak_weight_ff),
      .out_valid       (rsp_ch.valid),
      .match_score     (rsp_ch.match_score),
      .strong_count    (rsp_ch.strong_count),
      .medium_count    (rsp_ch.medium_count),
      .weak_count      (rsp_ch.weak_count),
      .very_weak_count (rsp_ch.very_weak_count),
      .mismatch_count  (rsp_ch.mismatch_count),
      .bailed          (rsp_ch.bailed)
   );

   `ASSERT_IMPLY(a_bail_has_mismatch, clock, reset, rsp_ch.valid && rsp_ch.bailed,
                 rsp_ch.mismatch_count != 16'd0)
   `ASSERT_IMPLY(a_result_needs_advance, clock, reset, $rose(rsp_ch.valid), $past(pipe_en))
   `ASSERT_ALWAYS(a_tally_bail_nonzero, clock, reset,
                  !(t_ctrl.valid && t_ctrl.bailed) || (t_mism != '0))

endmodule

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the degenerate base scorer. Base pairs queued by the
// stimulus process are driven with random gaps; every accepted pair updates a
// local grade and tally predictor, and every returned score is checked field
// by field against the oldest owed score. Register settings change between
// drained phases and include the extremes.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int RANDOM_ITEMS = 1850;

   typedef struct packed {
      logic [7:0]  base_a;
      logic [7:0]  base_b;
      logic [15:0] compare_length;
      logic        last_pair;
   } base_pair_type;

   typedef struct packed {
      logic [31:0] match_score;
      logic [15:0] strong_count;
      logic [15:0] medium_count;
      logic [15:0] weak_count;
      logic [15:0] very_weak_count;
      logic [15:0] mismatch_count;
      logic        bailed;
   } score_rec_type;

   logic                             clock;
   logic                             reset;
   logic                             csr_write_en;
   logic [dbms_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [dbms_pkg::CSR_DATA_W-1:0]  csr_wdata;

   dbms_req_if req_ch ();
   dbms_rsp_if rsp_ch ();

   degenerate_base_match_scorer dut (
      .clock        (clock),
      .reset        (reset),
      .req_ch       (req_ch),
      .rsp_ch       (rsp_ch),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   base_pair_type pair_stream[$];
   score_rec_type scores_owed[$];
   base_pair_type live_pair;
   int            pairs_queued  = 0;
   int            pairs_taken   = 0;
   int            error_count   = 0;
   int            cycle_count   = 0;
   int            gap_left      = 0;
   int            hold_left     = 0;
   bit            steady_sender = 1'b0;
   bit            steady_sink   = 1'b0;

   // scorer shadow: weights, limit setting and comparison state
   logic [7:0]  wt_strong  = dbms_pkg::STRONG_WEIGHT_RST;
   logic [7:0]  wt_medium  = dbms_pkg::MEDIUM_WEIGHT_RST;
   logic [7:0]  wt_weak    = dbms_pkg::WEAK_WEIGHT_RST;
   logic [7:0]  wt_run     = dbms_pkg::RUN_WEIGHT_MULT_RST;
   logic [9:0]  permille   = dbms_pkg::BAIL_PERMILLE_RST;
   logic [15:0] n_strong, n_medium, n_weak, n_very_weak, n_mismatch;
   logic [15:0] run_len, mis_limit;
   logic [31:0] run_weight;
   logic        halted     = 1'b0;
   logic        cmp_open   = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [3:0] bases_of(input logic [7:0] ch);
      case (ch)
         "A":     return 4'b0001;
         "C":     return 4'b0010;
         "G":     return 4'b0100;
         "T":     return 4'b1000;
         "R":     return 4'b0101;
         "Y":     return 4'b1010;
         "K":     return 4'b1100;
         "M":     return 4'b0011;
         "S":     return 4'b0110;
         "W":     return 4'b1001;
         "B":     return 4'b1110;
         "D":     return 4'b1101;
         "H":     return 4'b1011;
         "V":     return 4'b0111;
         "N":     return 4'b1111;
         default: return 4'b0000;
      endcase
   endfunction

   function automatic logic [15:0] plus_one(input logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

   function automatic logic [31:0] clip32(input logic [63:0] v);
      return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
   endfunction

   task automatic close_run();
      run_weight = clip32(64'(run_weight) + 64'(run_len) * 64'(wt_run) * 64'd2);
      run_len = '0;
   endtask

   task automatic take_pair(input base_pair_type p);
      logic [3:0]          set_a;
      logic [3:0]          set_b;
      logic [9:0]          pm_eff;
      dbms_pkg::grade_type g;
      logic [17:0]         graded;
      logic [63:0]         total;
      score_rec_type       r;
      if (!cmp_open) begin
         {n_strong, n_medium, n_weak, n_very_weak, n_mismatch, run_len} = '0;
         run_weight = '0;
         halted = 1'b0;
         pm_eff = (permille > dbms_pkg::PERMILLE_MAX) ? dbms_pkg::PERMILLE_MAX : permille;
         mis_limit = 16'((32'(p.compare_length) * 32'(pm_eff)) / dbms_pkg::THOUSAND);
         cmp_open = 1'b1;
      end
      if (!halted) begin
         set_a = bases_of(p.base_a);
         set_b = bases_of(p.base_b);
         if (p.base_a == "N") begin
            g = dbms_pkg::GRADE_VERY_WEAK;
         end else if ((set_a & set_b) == 4'b0000) begin
            g = dbms_pkg::GRADE_NONE;
         end else begin
            case ($countones(set_a))
               1:       g = dbms_pkg::GRADE_STRONG;
               2:       g = dbms_pkg::GRADE_MEDIUM;
               default: g = dbms_pkg::GRADE_WEAK;
            endcase
         end
         case (g)
            dbms_pkg::GRADE_STRONG:    n_strong = plus_one(n_strong);
            dbms_pkg::GRADE_MEDIUM:    n_medium = plus_one(n_medium);
            dbms_pkg::GRADE_WEAK:      n_weak = plus_one(n_weak);
            dbms_pkg::GRADE_VERY_WEAK: n_very_weak = plus_one(n_very_weak);
            default: ;
         endcase
         if (g != dbms_pkg::GRADE_NONE) begin
            run_len = plus_one(run_len);
         end else begin
            close_run();
            n_mismatch = plus_one(n_mismatch);
            if (n_mismatch >= mis_limit) halted = 1'b1;
         end
      end
      if (p.last_pair) begin
         if (!halted && run_len != 0) close_run();
         graded = 18'(n_strong) + 18'(n_medium) + 18'(n_weak);
         total = '0;
         if (n_strong != 0 && 18'(n_very_weak) <= graded) begin
            total = 64'(run_weight) + 64'(n_strong) * 64'(wt_strong)
                  + 64'(n_medium) * 64'(wt_medium) + 64'(n_weak) * 64'(wt_weak)
                  + 64'(n_very_weak);
         end
         r.match_score     = clip32(total);
         r.strong_count    = n_strong;
         r.medium_count    = n_medium;
         r.weak_count      = n_weak;
         r.very_weak_count = n_very_weak;
         r.mismatch_count  = n_mismatch;
         r.bailed          = halted;
         scores_owed.push_back(r);
         cmp_open = 1'b0;
      end
   endtask

   task automatic report_error(input string what, input logic [31:0] got,
                               input logic [31:0] want);
      $display("ERROR at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   function automatic int idle_span();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // item driver and predictor feed
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            take_pair(live_pair);
            pairs_taken++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (gap_left == 0 && pair_stream.size() != 0) begin
               live_pair = pair_stream.pop_front();
               req_ch.base_a         <= live_pair.base_a;
               req_ch.base_b         <= live_pair.base_b;
               req_ch.compare_length <= live_pair.compare_length;
               req_ch.last_pair      <= live_pair.last_pair;
               req_ch.valid          <= 1'b1;
               gap_left = steady_sender ? 0 : idle_span();
            end else begin
               req_ch.valid <= 1'b0;
               if (gap_left > 0) gap_left--;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      score_rec_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (scores_owed.size() == 0) begin
               report_error("unexpected result, score", rsp_ch.match_score, 0);
            end else begin
               want = scores_owed.pop_front();
               if (rsp_ch.match_score !== want.match_score)
                  report_error("match_score", rsp_ch.match_score, want.match_score);
               if (rsp_ch.strong_count !== want.strong_count)
                  report_error("strong_count", rsp_ch.strong_count, want.strong_count);
               if (rsp_ch.medium_count !== want.medium_count)
                  report_error("medium_count", rsp_ch.medium_count, want.medium_count);
               if (rsp_ch.weak_count !== want.weak_count)
                  report_error("weak_count", rsp_ch.weak_count, want.weak_count);
               if (rsp_ch.very_weak_count !== want.very_weak_count)
                  report_error("very_weak_count", rsp_ch.very_weak_count,
                               want.very_weak_count);
               if (rsp_ch.mismatch_count !== want.mismatch_count)
                  report_error("mismatch_count", rsp_ch.mismatch_count,
                               want.mismatch_count);
               if (rsp_ch.bailed !== want.bailed)
                  report_error("bailed", rsp_ch.bailed, want.bailed);
            end
         end
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (!steady_sink && $urandom_range(0, 3) == 0) hold_left = idle_span();
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic push_pair(input logic [7:0] a, input logic [7:0] b,
                            input logic [15:0] len, input logic last);
      pair_stream.push_back('{a, b, len, last});
      pairs_queued++;
   endtask

   function automatic logic [7:0] pick_base();
      string plain = "ACGT";
      string two   = "RYKMSW";
      string three = "BDHV";
      int    r;
      r = $urandom_range(0, 99);
      if (r < 45) return plain[$urandom_range(0, 3)];
      if (r < 65) return two[$urandom_range(0, 5)];
      if (r < 77) return three[$urandom_range(0, 3)];
      if (r < 85) return "N";
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic int pick_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return 1;
      if (r < 80) return $urandom_range(2, 16);
      if (r < 95) return $urandom_range(17, 40);
      return $urandom_range(41, 120);
   endfunction

   // well-formed comparisons mostly; some carry a stated length that is off
   task automatic queue_comparison(input int n);
      logic [15:0] len_field;
      logic [7:0]  a;
      logic [7:0]  b;
      case ($urandom_range(0, 9))
         7:       len_field = 16'd0;
         8:       len_field = 16'hFFFF;
         9:       len_field = 16'($urandom);
         default: len_field = 16'(n);
      endcase
      for (int i = 0; i < n; i++) begin
         a = pick_base();
         b = ($urandom_range(0, 2) == 0) ? a : pick_base();
         push_pair(a, b, (i == 0) ? len_field : 16'($urandom), i == n - 1);
      end
   endtask

   task automatic write_reg(input dbms_pkg::csr_index_type idx, input logic [9:0] val);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      case (idx)
         dbms_pkg::CSR_STRONG_WEIGHT:   wt_strong = val[7:0];
         dbms_pkg::CSR_MEDIUM_WEIGHT:   wt_medium = val[7:0];
         dbms_pkg::CSR_WEAK_WEIGHT:     wt_weak = val[7:0];
         dbms_pkg::CSR_RUN_WEIGHT_MULT: wt_run = val[7:0];
         dbms_pkg::CSR_BAIL_PERMILLE:   permille = val;
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [7:0] s, input logic [7:0] m,
                             input logic [7:0] w, input logic [7:0] rm,
                             input logic [9:0] pm);
      write_reg(dbms_pkg::CSR_STRONG_WEIGHT, 10'(s));
      write_reg(dbms_pkg::CSR_MEDIUM_WEIGHT, 10'(m));
      write_reg(dbms_pkg::CSR_WEAK_WEIGHT, 10'(w));
      write_reg(dbms_pkg::CSR_RUN_WEIGHT_MULT, 10'(rm));
      write_reg(dbms_pkg::CSR_BAIL_PERMILLE, pm);
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   function automatic logic [7:0] pick_weight();
      case ($urandom_range(0, 4))
         0:       return 8'd0;
         1:       return 8'd255;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [9:0] pick_permille();
      case ($urandom_range(0, 5))
         0:       return 10'd0;
         1:       return 10'd1000;
         2:       return 10'd1023;
         3:       return 10'($urandom_range(0, 1023));
         default: return 10'($urandom_range(100, 400));
      endcase
   endfunction

   // hold until every item is taken and every score is back, then settle
   task automatic drain();
      while (pairs_taken != pairs_queued || scores_owed.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   initial begin
      int batch;
      int done_items;
      int phase;
      reset                 = 1'b1;
      req_ch.valid          = 1'b0;
      req_ch.base_a         = '0;
      req_ch.base_b         = '0;
      req_ch.compare_length = '0;
      req_ch.last_pair      = 1'b0;
      rsp_ch.ready          = 1'b0;
      csr_write_en          = 1'b0;
      csr_index             = '0;
      csr_wdata             = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      push_pair("A", "A", 16'd1, 1'b1);

      push_pair("C", "C", 16'hFFFF, 1'b0);
      push_pair("R", "G", 16'd0, 1'b0);
      push_pair("B", "T", 16'd0, 1'b0);
      push_pair("N", 8'h00, 16'd0, 1'b0);
      push_pair("G", "C", 16'hFFFF, 1'b0);
      push_pair(8'hFF, "A", 16'd0, 1'b0);
      push_pair("A", "a", 16'd0, 1'b0);
      push_pair("N", "N", 16'd0, 1'b1);

      push_pair("A", "A", 16'd0, 1'b0);
      push_pair("T", "G", 16'd0, 1'b0);
      push_pair("A", "A", 16'd0, 1'b0);
      push_pair("C", "C", 16'd0, 1'b1);

      push_pair("N", "A", 16'd3, 1'b0);
      push_pair("N", "N", 16'd3, 1'b0);
      push_pair("A", "A", 16'd3, 1'b1);

      push_pair("R", "A", 16'd1, 1'b1);
      drain();

      done_items = 0;
      phase = 0;
      while (done_items < RANDOM_ITEMS) begin
         if (phase == 0) begin
            set_config(8'd255, 8'd255, 8'd255, 8'd255, 10'd1023);
         end else if (phase == 1) begin
            set_config(8'd0, 8'd0, 8'd0, 8'd0, 10'd0);
         end else begin
            set_config(pick_weight(), pick_weight(), pick_weight(), pick_weight(),
                       pick_permille());
         end
         steady_sender = ($urandom_range(0, 3) == 0);
         steady_sink   = ($urandom_range(0, 3) == 0);
         batch = 0;
         while (batch < 150) begin
            int n;
            n = pick_length();
            queue_comparison(n);
            batch += n;
         end
         done_items += batch;
         drain();
         phase++;
      end

      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/dbms_pkg.sv
rtl/core/dbms_channels.sv
rtl/core/dbms_grader.sv
rtl/core/dbms_tally.sv
rtl/core/dbms_score.sv
rtl/core/degenerate_base_match_scorer.sv
dv/tb.sv
